/* src/swpwt_pkg.sv */
// swpwt_pkg: shared types and constants for the single-wire pulse-width transmitter
// holds the word structs, the timing register set, the phase encoding and register indexes
// no dependencies
package swpwt_pkg;

   // timing register file geometry
   localparam int unsigned RegCount = 8;
   localparam int unsigned RegIdxW  = $clog2(RegCount);
   localparam int unsigned AddrW    = RegIdxW + 2;
   localparam int unsigned DataW    = 32;
   localparam int unsigned TimeW    = 8;
   localparam int unsigned BitIdxW  = 3;

   // register indexes
   typedef enum logic [RegIdxW-1:0] {
      REG_ONE_LOW       = 3'd0,
      REG_ZERO_LOW      = 3'd1,
      REG_ONE_HIGH      = 3'd2,
      REG_ZERO_HIGH     = 3'd3,
      REG_ONE_STOP_HIGH = 3'd4,
      REG_ZERO_STOP_HIGH= 3'd5,
      REG_BREAK_LOW     = 3'd6,
      REG_BREAK_HIGH    = 3'd7
   } reg_idx_type;

   // reset values of the timing registers, in microsecond ticks
   localparam logic [TimeW-1:0] OneLowReset      = 8'd2;
   localparam logic [TimeW-1:0] ZeroLowReset     = 8'd7;
   localparam logic [TimeW-1:0] OneHighReset     = 8'd9;
   localparam logic [TimeW-1:0] ZeroHighReset    = 8'd4;
   localparam logic [TimeW-1:0] OneStopHighReset = 8'd21;
   localparam logic [TimeW-1:0] ZeroStopHighReset= 8'd16;
   localparam logic [TimeW-1:0] BreakLowReset    = 8'd14;
   localparam logic [TimeW-1:0] BreakHighReset   = 8'd5;

   // last bit of a byte, which takes the stop recovery time
   localparam logic [BitIdxW-1:0] LastBit = 3'd7;

   // input word kinds
   localparam logic ReqTick = 1'b0;
   localparam logic ReqLoad = 1'b1;

   // line phases
   typedef enum logic [2:0] {
      PH_IDLE      = 3'd0,
      PH_BIT_LOW   = 3'd1,
      PH_BIT_HIGH  = 3'd2,
      PH_BRK_LOW   = 3'd3,
      PH_BRK_HIGH  = 3'd4
   } phase_type;

   // timing register set
   typedef struct packed {
      logic [TimeW-1:0] one_low_us;
      logic [TimeW-1:0] zero_low_us;
      logic [TimeW-1:0] one_high_us;
      logic [TimeW-1:0] zero_high_us;
      logic [TimeW-1:0] one_stop_high_us;
      logic [TimeW-1:0] zero_stop_high_us;
      logic [TimeW-1:0] break_low_us;
      logic [TimeW-1:0] break_high_us;
   } timing_type;

   // input word
   typedef struct packed {
      logic             req_type;
      logic [7:0]       tx_byte;
      logic             end_of_frame;
   } req_item_type;

   // result word
   typedef struct packed {
      logic line_level;
      logic busy_res;
      logic accepted;
   } rsp_item_type;

endpackage

/* src/single_wire_pulse_width_transmitter.sv */
// single_wire_pulse_width_transmitter: top level of the single-wire pulse-width line driver
// depends on swpwt_pkg, swpwt_csr and swpwt_engine
//
// Each input word is either a one-microsecond tick or a byte load; every word gives exactly
// one result word carrying the line level, the busy flag and whether a load was taken. A byte
// is sent least significant bit first, each bit a low time then a recovery time, with a break
// after bytes marked end of frame; all times come from eight 8-bit tick-count registers at
// byte addresses 0 to 28. A word passes through an input register and then the phase
// sequencer into the result register; one word is taken every cycle as long as results
// are drained, since the sequencer updates its phase and tick counter as each word is
// applied.
module single_wire_pulse_width_transmitter (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  swpwt_pkg::req_item_type       req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output swpwt_pkg::rsp_item_type       rsp_data,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [swpwt_pkg::AddrW-1:0]   csr_paddr,
   input  logic [swpwt_pkg::DataW-1:0]   csr_pwdata,
   output logic [swpwt_pkg::DataW-1:0]   csr_prdata,
   output logic                          csr_pready
);

   swpwt_pkg::timing_type   timing;
   swpwt_pkg::req_item_type item_ff, item_in;
   logic                    item_valid_ff, item_valid_in;
   swpwt_pkg::rsp_item_type rsp_ff, rsp_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   swpwt_pkg::rsp_item_type res;
   logic                    out_free;
   logic                    item_step;
   logic                    req_fire;

   swpwt_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .timing      (timing)
   );

   // handshake control
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign item_step = item_valid_ff && out_free;
   assign req_ready = !item_valid_ff || out_free;
   assign req_fire  = req_valid && req_ready;

   // input register
   always_comb begin
      item_in       = req_fire ? req_data : item_ff;
      item_valid_in = req_fire || (item_valid_ff && !item_step);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   swpwt_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .step   (item_step),
      .item   (item_ff),
      .timing (timing),
      .res    (res)
   );

   // result register
   always_comb begin
      rsp_in       = item_step ? res : rsp_ff;
      rsp_valid_in = item_step || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* src/swpwt_csr.sv */
// swpwt_csr: timing register file behind an APB-style write/read port
// depends on swpwt_pkg
module swpwt_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [swpwt_pkg::AddrW-1:0]       csr_paddr,
   input  logic [swpwt_pkg::DataW-1:0]       csr_pwdata,
   output logic [swpwt_pkg::DataW-1:0]       csr_prdata,
   output logic                              csr_pready,
   output swpwt_pkg::timing_type             timing
);

   logic [swpwt_pkg::TimeW-1:0] regs_ff [swpwt_pkg::RegCount];
   logic [swpwt_pkg::TimeW-1:0] regs_in [swpwt_pkg::RegCount];
   swpwt_pkg::reg_idx_type      idx;
   logic                        wr_en;

   assign csr_pready = 1'b1;
   assign idx   = swpwt_pkg::reg_idx_type'(csr_paddr[swpwt_pkg::AddrW-1:2]);
   assign wr_en = csr_psel && csr_penable && csr_pwrite;

   // write decode
   always_comb begin
      for (int i = 0; i < swpwt_pkg::RegCount; i++) begin
         regs_in[i] = regs_ff[i];
      end
      if (wr_en) begin
         regs_in[idx] = csr_pwdata[swpwt_pkg::TimeW-1:0];
      end
   end

   // register file with reset values
   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff[swpwt_pkg::REG_ONE_LOW]        <= swpwt_pkg::OneLowReset;
         regs_ff[swpwt_pkg::REG_ZERO_LOW]       <= swpwt_pkg::ZeroLowReset;
         regs_ff[swpwt_pkg::REG_ONE_HIGH]       <= swpwt_pkg::OneHighReset;
         regs_ff[swpwt_pkg::REG_ZERO_HIGH]      <= swpwt_pkg::ZeroHighReset;
         regs_ff[swpwt_pkg::REG_ONE_STOP_HIGH]  <= swpwt_pkg::OneStopHighReset;
         regs_ff[swpwt_pkg::REG_ZERO_STOP_HIGH] <= swpwt_pkg::ZeroStopHighReset;
         regs_ff[swpwt_pkg::REG_BREAK_LOW]      <= swpwt_pkg::BreakLowReset;
         regs_ff[swpwt_pkg::REG_BREAK_HIGH]     <= swpwt_pkg::BreakHighReset;
      end else begin
         for (int i = 0; i < swpwt_pkg::RegCount; i++) begin
            regs_ff[i] <= regs_in[i];
         end
      end
   end

   // read back, zero extended
   assign csr_prdata = {{(swpwt_pkg::DataW-swpwt_pkg::TimeW){1'b0}}, regs_ff[idx]};

   // register set to the engine
   assign timing.one_low_us        = regs_ff[swpwt_pkg::REG_ONE_LOW];
   assign timing.zero_low_us       = regs_ff[swpwt_pkg::REG_ZERO_LOW];
   assign timing.one_high_us       = regs_ff[swpwt_pkg::REG_ONE_HIGH];
   assign timing.zero_high_us      = regs_ff[swpwt_pkg::REG_ZERO_HIGH];
   assign timing.one_stop_high_us  = regs_ff[swpwt_pkg::REG_ONE_STOP_HIGH];
   assign timing.zero_stop_high_us = regs_ff[swpwt_pkg::REG_ZERO_STOP_HIGH];
   assign timing.break_low_us      = regs_ff[swpwt_pkg::REG_BREAK_LOW];
   assign timing.break_high_us     = regs_ff[swpwt_pkg::REG_BREAK_HIGH];

endmodule

/* src/swpwt_engine.sv */
// swpwt_engine: line phase sequencer, one word applied per enabled cycle
// depends on swpwt_pkg; result is combinational and registered by the top level
module swpwt_engine (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  swpwt_pkg::req_item_type item,
   input  swpwt_pkg::timing_type  timing,
   output swpwt_pkg::rsp_item_type res
);

   swpwt_pkg::phase_type              phase_ff, phase_in;
   logic [swpwt_pkg::TimeW-1:0]       time_left_ff, time_left_in;
   logic [7:0]                        shift_byte_ff, shift_byte_in;
   logic [swpwt_pkg::BitIdxW-1:0]     bit_index_ff, bit_index_in;
   logic                              break_pending_ff, break_pending_in;

   logic                              cur_bit;
   logic                              next_bit;
   logic [swpwt_pkg::BitIdxW-1:0]     bit_next_idx;
   logic [swpwt_pkg::TimeW-1:0]       high_time;
   logic                              phase_done;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= swpwt_pkg::PH_IDLE;
         time_left_ff     <= '0;
         shift_byte_ff    <= '0;
         bit_index_ff     <= '0;
         break_pending_ff <= 1'b0;
      end else if (step) begin
         phase_ff         <= phase_in;
         time_left_ff     <= time_left_in;
         shift_byte_ff    <= shift_byte_in;
         bit_index_ff     <= bit_index_in;
         break_pending_ff <= break_pending_in;
      end
   end

   // bit selection and recovery time of the current bit
   assign cur_bit      = shift_byte_ff[bit_index_ff];
   assign bit_next_idx = bit_index_ff + 1'b1;
   assign next_bit     = shift_byte_ff[bit_next_idx];
   assign phase_done   = (time_left_ff <= 8'd1);

   always_comb begin
      if (bit_index_ff == swpwt_pkg::LastBit) begin
         high_time = cur_bit ? timing.one_stop_high_us : timing.zero_stop_high_us;
      end else begin
         high_time = cur_bit ? timing.one_high_us : timing.zero_high_us;
      end
   end

   // next state and result
   always_comb begin
      phase_in         = phase_ff;
      time_left_in     = time_left_ff;
      shift_byte_in    = shift_byte_ff;
      bit_index_in     = bit_index_ff;
      break_pending_in = break_pending_ff;
      res.accepted     = 1'b0;

      case (phase_ff)
         swpwt_pkg::PH_BIT_LOW: begin
            if (item.req_type == swpwt_pkg::ReqTick) begin
               if (phase_done) begin
                  phase_in     = swpwt_pkg::PH_BIT_HIGH;
                  time_left_in = high_time;
               end else begin
                  time_left_in = time_left_ff - 1'b1;
               end
            end
         end
         swpwt_pkg::PH_BIT_HIGH: begin
            if (item.req_type == swpwt_pkg::ReqTick) begin
               if (!phase_done) begin
                  time_left_in = time_left_ff - 1'b1;
               end else if (bit_index_ff != swpwt_pkg::LastBit) begin
                  bit_index_in = bit_next_idx;
                  phase_in     = swpwt_pkg::PH_BIT_LOW;
                  time_left_in = next_bit ? timing.one_low_us : timing.zero_low_us;
               end else if (break_pending_ff) begin
                  phase_in     = swpwt_pkg::PH_BRK_LOW;
                  time_left_in = timing.break_low_us;
               end else begin
                  phase_in     = swpwt_pkg::PH_IDLE;
                  time_left_in = '0;
               end
            end
         end
         swpwt_pkg::PH_BRK_LOW: begin
            if (item.req_type == swpwt_pkg::ReqTick) begin
               if (phase_done) begin
                  phase_in     = swpwt_pkg::PH_BRK_HIGH;
                  time_left_in = timing.break_high_us;
               end else begin
                  time_left_in = time_left_ff - 1'b1;
               end
            end
         end
         swpwt_pkg::PH_BRK_HIGH: begin
            if (item.req_type == swpwt_pkg::ReqTick) begin
               if (phase_done) begin
                  phase_in         = swpwt_pkg::PH_IDLE;
                  time_left_in     = '0;
                  break_pending_in = 1'b0;
               end else begin
                  time_left_in = time_left_ff - 1'b1;
               end
            end
         end
         default: begin
            // idle: ticks do nothing, a load starts bit 0 with the line low
            phase_in     = swpwt_pkg::PH_IDLE;
            time_left_in = '0;
            if (item.req_type == swpwt_pkg::ReqLoad) begin
               shift_byte_in    = item.tx_byte;
               break_pending_in = item.end_of_frame;
               bit_index_in     = '0;
               phase_in         = swpwt_pkg::PH_BIT_LOW;
               time_left_in     = item.tx_byte[0] ? timing.one_low_us : timing.zero_low_us;
               res.accepted     = 1'b1;
            end
         end
      endcase

      res.line_level = !((phase_in == swpwt_pkg::PH_BIT_LOW) ||
                         (phase_in == swpwt_pkg::PH_BRK_LOW));
      res.busy_res   = (phase_in != swpwt_pkg::PH_IDLE);
   end

   // a load is only taken from idle
   a_accept_from_idle: assert property (@(posedge clock) disable iff (reset)
      step && res.accepted |-> phase_ff == swpwt_pkg::PH_IDLE)
      else $error("load taken while line busy");

   // the counter stays cleared while idle
   a_idle_no_time: assert property (@(posedge clock)
      phase_ff == swpwt_pkg::PH_IDLE |-> time_left_ff == '0)
      else $error("time left non-zero in idle");

   // state only moves when a word is applied
   a_hold_without_step: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(phase_ff) && $stable(time_left_ff) && $stable(bit_index_ff))
      else $error("state changed without a word");

   // reported busy matches the phase left behind
   a_busy_tracks_phase: assert property (@(posedge clock) disable iff (reset)
      step |=> (phase_ff != swpwt_pkg::PH_IDLE) == $past(res.busy_res))
      else $error("busy flag disagrees with phase");

endmodule
